@@ design/sem_pkg.sv @@
package sem_pkg;

  localparam int PIX_W   = 24;
  localparam int CHAN_W  = 8;
  localparam int SLOTS   = 4;
  localparam int ROOT_W  = 8;
  localparam int STEP_W  = 3;
  localparam int GRAD_W  = 12;
  localparam int SUM_W   = 23;
  localparam int CFG_W   = 11;
  localparam int ROW_W   = 10;
  localparam int HEIGHT_LIMIT = 1024;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic              capture;
    logic              shift;
    logic              square;
    logic              root_step;
    logic [STEP_W-1:0] root_bit;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic [SLOTS-1:0] pending;
    logic             out_busy;
  } status_t;

endpackage

@@ design/sobel_edge_magnitude_top.sv @@
// Channel  Signals                                   Transfer
// in       in_valid, in_stall, red/green/blue_in     valid high, stall low
// out      out_valid, out_stall, red/green/blue_out, valid high, stall low
//          last_of_run, frame_end
// cfg      psel, penable, pwrite, paddr, pwdata      APB, pready tied high
//
// Each pixel is captured, shifted into the window and squared, then passes the
// eight-step square root before its results (0 to 4) are emitted. Line buffers
// are two single-port-write RAMs of MAX_WIDTH entries with a registered read.
// Reset is synchronous and clears counters, window and control; line buffer
// contents stay undefined until written.
// An output stall holds the result and the controller waits.
module sobel_edge_magnitude_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        last_of_run,
  output logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sem_pkg::*;

  logic [CFG_W-1:0] image_width, image_height;
  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = paddr[2] == REG_HEIGHT ? 32'(image_height) : 32'(image_width);
  assign pready = 1'b1;

  sem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .image_width  (image_width),
    .image_height (image_height),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .last_of_run  (last_of_run),
    .frame_end    (frame_end)
  );

endmodule

@@ design/sem_ram.sv @@
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/sem_ctrl.sv @@
module sem_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  sem_pkg::status_t status,
  output sem_pkg::cmd_t   cmd
);
  import sem_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_SQ    = 5'b00100,
    S_ROOT  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.root_bit = step;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        step_next  = STEP_W'(ROOT_W - 1);
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (step == '0) begin
          state_next = S_EMIT;
        end else begin
          step_next = step - 1'b1;
        end
      end
      S_EMIT: begin
        if (status.pending == '0) begin
          state_next = S_IDLE;
        end else if (!status.out_busy) begin
          cmd.emit = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

@@ design/sem_datapath.sv @@
module sem_datapath #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sem_pkg::cmd_t              cmd,
  output sem_pkg::status_t           status,
  input  logic [sem_pkg::CFG_W-1:0]  image_width,
  input  logic [sem_pkg::CFG_W-1:0]  image_height,
  input  logic [sem_pkg::CHAN_W-1:0] red_in,
  input  logic [sem_pkg::CHAN_W-1:0] green_in,
  input  logic [sem_pkg::CHAN_W-1:0] blue_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sem_pkg::CHAN_W-1:0] red_out,
  output logic [sem_pkg::CHAN_W-1:0] green_out,
  output logic [sem_pkg::CHAN_W-1:0] blue_out,
  output logic                       last_of_run,
  output logic                       frame_end
);
  import sem_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam int HW = CFG_W;

  logic [AW-1:0]    column_count;
  logic [ROW_W-1:0] row_count;

  logic [WW-1:0] w_ext, w_eff, cc_wide;
  logic [HW-1:0] h_eff, rr_wide;
  logic [AW-1:0]    cc_now, cc, cc_last;
  logic [ROW_W-1:0] rr_now, rr, rr_last;

  always_comb begin
    w_ext = WW'(image_width);
    if (w_ext < WW'(3)) w_eff = WW'(3);
    else if (w_ext > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = w_ext;
    if (image_height < HW'(3)) h_eff = HW'(3);
    else if (image_height > HW'(HEIGHT_LIMIT)) h_eff = HW'(HEIGHT_LIMIT);
    else h_eff = image_height;
    cc_wide = (WW'(column_count) > w_eff - 1'b1) ? w_eff - 1'b1 : WW'(column_count);
    rr_wide = (HW'(row_count) > h_eff - 1'b1) ? h_eff - 1'b1 : HW'(row_count);
    cc_now  = cc_wide[AW-1:0];
    rr_now  = rr_wide[ROW_W-1:0];
  end

  logic [WW-1:0] w_last_r;
  logic [HW-1:0] h_last_r;
  logic [PIX_W-1:0] px, top_rd, mid_rd;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px       <= {blue_in, green_in, red_in};
      cc       <= cc_now;
      rr       <= rr_now;
      w_last_r <= w_eff - 1'b1;
      h_last_r <= h_eff - 1'b1;
    end
  end

  assign cc_last = w_last_r[AW-1:0];
  assign rr_last = h_last_r[ROW_W-1:0];

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk   (clk),
    .we    (cmd.shift),
    .waddr (cc),
    .wdata (px),
    .raddr (cc_now),
    .rdata (mid_rd)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_top_ram (
    .clk   (clk),
    .we    (cmd.shift),
    .waddr (cc),
    .wdata (mid_rd),
    .raddr (cc_now),
    .rdata (top_rd)
  );

  logic [PIX_W-1:0] win [9];
  logic [PIX_W-1:0] win_next [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i*3+0] = win[i*3+1];
      win_next[i*3+1] = win[i*3+2];
    end
    win_next[2] = top_rd;
    win_next[5] = mid_rd;
    win_next[8] = px;
  end

  logic signed [GRAD_W-1:0] gx_next, gy_next, gx, gy;

  function automatic logic signed [GRAD_W-1:0] red_of(input logic [PIX_W-1:0] p);
    return $signed({{(GRAD_W-CHAN_W){1'b0}}, p[CHAN_W-1:0]});
  endfunction

  always_comb begin
    gx_next = red_of(win_next[0]) - red_of(win_next[2])
            + (red_of(win_next[3]) <<< 1) - (red_of(win_next[5]) <<< 1)
            + red_of(win_next[6]) - red_of(win_next[8]);
    gy_next = red_of(win_next[0]) + (red_of(win_next[1]) <<< 1) + red_of(win_next[2])
            - red_of(win_next[6]) - (red_of(win_next[7]) <<< 1) - red_of(win_next[8]);
  end

  logic [SLOTS-1:0] pending;
  logic             interior;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.shift) begin
      for (int i = 0; i < 9; i++) win[i] <= win_next[i];
      if (cc == cc_last) begin
        column_count <= '0;
        row_count    <= (rr == rr_last) ? '0 : rr + 1'b1;
      end else begin
        column_count <= cc + 1'b1;
        row_count    <= rr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (cmd.shift) begin
      pending[0] <= (rr != '0) && (cc != '0);
      pending[1] <= (rr != '0) && (cc == cc_last);
      pending[2] <= (rr != '0) && (rr == rr_last) && (cc != '0);
      pending[3] <= (rr != '0) && (rr == rr_last) && (cc == cc_last);
    end else if (cmd.emit) begin
      pending <= pending & (pending - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      gx       <= gx_next;
      gy       <= gy_next;
      interior <= (rr > ROW_W'(1)) && (cc > AW'(1));
    end
  end

  logic [SUM_W-1:0] sumsq;
  logic             sat;
  logic [ROOT_W-1:0] root, cand;
  logic [2*ROOT_W-1:0] cand_sq;
  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sumsq <= SUM_W'(unsigned'(gx_sq)) + SUM_W'(unsigned'(gy_sq));
      root  <= '0;
    end else if (cmd.root_step) begin
      if (SUM_W'(cand_sq) <= sumsq) root <= cand;
    end
  end

  always_comb begin
    gx_sq   = gx * gx;
    gy_sq   = gy * gy;
    cand    = root | (ROOT_W'(1) << cmd.root_bit);
    cand_sq = cand * cand;
    sat     = (sumsq >> (2 * ROOT_W)) != '0;
  end

  logic [CHAN_W-1:0] mag;
  logic [PIX_W-1:0]  slot_px;
  logic              slot_fe;

  always_comb begin
    mag     = sat ? '1 : root;
    slot_fe = 1'b0;
    if (pending[0]) begin
      slot_px = interior ? {mag, mag, mag} : win[4];
    end else if (pending[1]) begin
      slot_px = win[5];
    end else if (pending[2]) begin
      slot_px = win[7];
    end else begin
      slot_px = win[8];
      slot_fe = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      red_out     <= slot_px[CHAN_W-1:0];
      green_out   <= slot_px[2*CHAN_W-1:CHAN_W];
      blue_out    <= slot_px[3*CHAN_W-1:2*CHAN_W];
      last_of_run <= (pending & (pending - 1'b1)) == '0;
      frame_end   <= slot_fe;
    end
  end

  assign status.pending  = pending;
  assign status.out_busy = out_valid && out_stall;

endmodule
